/* design/smu_pkg.sv */
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and constants of the segmented memory unit.
// ----------------------------------------------------------------------------
package smu_pkg;

  localparam int NumSegmentsDef  = 64;
  localparam int SegmentWordsDef = 1024;
  localparam int DataW           = 32;
  localparam int OpW             = 3;
  localparam int CounterW        = 10;
  localparam int StatusW         = 3;

  typedef enum logic [OpW-1:0] {
    OP_MAP      = 3'd0,
    OP_UNMAP    = 3'd1,
    OP_LOAD     = 3'd2,
    OP_STORE    = 3'd3,
    OP_LOAD_PRG = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_UNMAPPED   = 3'd1,
    ST_BOUNDS     = 3'd2,
    ST_UNMAP_ZERO = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_NO_ID      = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_EVAL,
    S_FILL,
    S_COPY_RD,
    S_COPY_WR,
    S_WORD_WAIT,
    S_FINISH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_LOOKUP,
    CMD_EVAL,
    CMD_FILL,
    CMD_FILL_END,
    CMD_COPY_RD,
    CMD_COPY_WR,
    CMD_COPY_END,
    CMD_FINISH
  } cmd_e;

  // Datapath report to the controller
  typedef struct packed {
    logic [OpW-1:0] op;
    status_e        status;
    logic           walk_done;
  } ctl_status_t;

endpackage

/* design/smu_if.sv */
// ----------------------------------------------------------------------------
// smu_in_if / smu_out_if
// Valid/ready channels carrying operation items and result items.
// ----------------------------------------------------------------------------
interface smu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] segment;
  logic [31:0] offset;
  logic [31:0] value;

  modport source (output valid, output op, output segment, output offset,
                  output value, input ready);
  modport sink   (input valid, input op, input segment, input offset,
                  input value, output ready);
endinterface

interface smu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  logic [9:0]  new_counter;
  logic [2:0]  status;

  modport source (output valid, output data, output new_counter, output status,
                  input ready);
  modport sink   (input valid, input data, input new_counter, input status,
                  output ready);
endinterface

/* design/smu_datapath.sv */
// ----------------------------------------------------------------------------
// smu_datapath
// Operand registers, segment table, free id stack, word memory and result
// registers. Acts on one command from the controller per cycle.
// ----------------------------------------------------------------------------
module smu_datapath
  import smu_pkg::*;
#(
  parameter int NUM_SEGMENTS  = NumSegmentsDef,
  parameter int SEGMENT_WORDS = SegmentWordsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  input  logic [OpW-1:0]      op_i,
  input  logic [DataW-1:0]    segment_i,
  input  logic [DataW-1:0]    offset_i,
  input  logic [DataW-1:0]    value_i,
  output ctl_status_t         status_o,
  output logic [DataW-1:0]    data_o,
  output logic [CounterW-1:0] new_counter_o,
  output logic [StatusW-1:0]  status_code_o
);

  localparam int SegW  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int CntW  = $clog2(NUM_SEGMENTS + 1);
  localparam int LenW  = $clog2(SEGMENT_WORDS + 1);
  localparam int AddrW = $clog2(NUM_SEGMENTS * SEGMENT_WORDS);
  localparam int TotalWords = NUM_SEGMENTS * SEGMENT_WORDS;
  localparam logic [AddrW-1:0] Stride   = AddrW'(SEGMENT_WORDS);
  localparam logic [DataW-1:0] MaxLen   = DataW'(SEGMENT_WORDS);
  localparam logic [DataW-1:0] NumSegs  = DataW'(NUM_SEGMENTS);
  localparam logic [CntW-1:0]  NumIds   = CntW'(NUM_SEGMENTS);

  // Operand registers
  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] seg_q, off_q, val_q;

  // Segment table entry: mapped flag over length
  logic [LenW:0]    tab_mem [NUM_SEGMENTS];
  logic [SegW-1:0]  stk_mem [NUM_SEGMENTS];
  logic [DataW-1:0] word_mem [TotalWords];

  logic [LenW:0]    tab_rd_q;
  logic [SegW-1:0]  stk_rd_q;
  logic [DataW-1:0] word_rd_q;

  logic [CntW-1:0]  free_cnt_q, fresh_q;
  logic [LenW-1:0]  len0_q;
  logic [SegW-1:0]  id_q;
  logic [LenW-1:0]  cnt_q, walk_len_q;
  status_e          stat_q;

  logic [DataW-1:0]    res_data_q;
  logic [CounterW-1:0] res_ctr_q;
  logic [StatusW-1:0]  res_stat_q;

  logic [SegW-1:0] seg_idx;
  logic            seg_in, mapped, in_bounds;
  logic [LenW-1:0] len_cur;
  status_e         stat_d;

  assign seg_idx = seg_q[SegW-1:0];
  assign seg_in  = seg_q < NumSegs;
  assign mapped  = seg_in && ((seg_idx == '0) ||
                   ((CntW'(seg_idx) < fresh_q) && tab_rd_q[LenW]));
  assign len_cur   = (seg_idx == '0) ? len0_q : tab_rd_q[LenW-1:0];
  assign in_bounds = off_q < DataW'(len_cur);

  // Check the operation against the looked-up state
  always_comb begin
    stat_d = ST_OK;
    case (op_q)
      OP_MAP: begin
        if (val_q > MaxLen) stat_d = ST_TOO_LONG;
        else if (free_cnt_q == '0 && fresh_q >= NumIds) stat_d = ST_NO_ID;
      end
      OP_UNMAP: begin
        if (!mapped) stat_d = ST_UNMAPPED;
        else if (seg_idx == '0) stat_d = ST_UNMAP_ZERO;
      end
      OP_LOAD, OP_STORE, OP_LOAD_PRG: begin
        if (!mapped) stat_d = ST_UNMAPPED;
        else if (!in_bounds) stat_d = ST_BOUNDS;
      end
      default: stat_d = ST_OK;
    endcase
  end

  assign status_o.op        = op_q;
  assign status_o.status    = stat_d;
  assign status_o.walk_done = (cnt_q == walk_len_q);

  // Word memory port select
  logic             w_we, w_re;
  logic [SegW-1:0]  row_sel;
  logic [AddrW-1:0] col_sel, w_addr;
  logic [DataW-1:0] w_wdata;

  always_comb begin
    w_we    = 1'b0;
    w_re    = 1'b0;
    row_sel = seg_idx;
    col_sel = AddrW'(off_q);
    w_wdata = '0;
    case (cmd_i)
      CMD_EVAL: begin
        if (stat_d == ST_OK && op_q == OP_STORE) begin
          w_we    = 1'b1;
          w_wdata = val_q;
        end
        if (stat_d == ST_OK && op_q == OP_LOAD) w_re = 1'b1;
      end
      CMD_FILL: begin
        w_we    = 1'b1;
        row_sel = id_q;
        col_sel = AddrW'(cnt_q);
      end
      CMD_COPY_RD: begin
        w_re    = 1'b1;
        col_sel = AddrW'(cnt_q);
      end
      CMD_COPY_WR: begin
        w_we    = 1'b1;
        row_sel = '0;
        col_sel = AddrW'(cnt_q);
        w_wdata = word_rd_q;
      end
      default: ;
    endcase
  end

  assign w_addr = AddrW'(row_sel) * Stride + col_sel;

  always_ff @(posedge clk_i) begin
    if (w_we) word_mem[w_addr] <= w_wdata;
    if (w_re) word_rd_q <= word_mem[w_addr];
  end

  // Segment table and stack ports
  logic            t_we, s_we;
  logic [SegW-1:0] t_addr;
  logic [LenW:0]   t_wdata;

  always_comb begin
    t_we    = 1'b0;
    t_addr  = seg_idx;
    t_wdata = '0;
    s_we    = 1'b0;
    if (cmd_i == CMD_EVAL && stat_d == ST_OK && op_q == OP_UNMAP &&
        free_cnt_q < NumIds) begin
      t_we = 1'b1;
      s_we = 1'b1;
    end
    if (cmd_i == CMD_FILL_END) begin
      t_we    = 1'b1;
      t_addr  = id_q;
      t_wdata = {1'b1, walk_len_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_we) tab_mem[t_addr] <= t_wdata;
    if (s_we) stk_mem[free_cnt_q[SegW-1:0]] <= seg_idx;
    if (cmd_i == CMD_LOOKUP) begin
      tab_rd_q <= tab_mem[seg_idx];
      stk_rd_q <= stk_mem[SegW'(free_cnt_q - CntW'(1))];
    end
  end

  // Operand capture, id bookkeeping and walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_cnt_q <= '0;
      fresh_q    <= CntW'(1);
      len0_q     <= '0;
    end else begin
      if (cmd_i == CMD_EVAL && stat_d == ST_OK) begin
        if (op_q == OP_MAP) begin
          if (free_cnt_q != '0) free_cnt_q <= free_cnt_q - CntW'(1);
          else fresh_q <= fresh_q + CntW'(1);
        end
        if (s_we) free_cnt_q <= free_cnt_q + CntW'(1);
      end
      if (cmd_i == CMD_COPY_END && seg_idx != '0) len0_q <= walk_len_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_LATCH) begin
      op_q  <= op_i;
      seg_q <= segment_i;
      off_q <= offset_i;
      val_q <= value_i;
    end
    if (cmd_i == CMD_EVAL) begin
      stat_q <= stat_d;
      cnt_q  <= '0;
      if (op_q == OP_MAP) begin
        id_q       <= (free_cnt_q != '0) ? stk_rd_q : fresh_q[SegW-1:0];
        walk_len_q <= val_q[LenW-1:0];
      end else begin
        walk_len_q <= (seg_idx == '0) ? '0 : len_cur;
      end
    end
    if (cmd_i == CMD_FILL || cmd_i == CMD_COPY_WR) cnt_q <= cnt_q + LenW'(1);
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i == CMD_FINISH) begin
      res_data_q <= '0;
      res_ctr_q  <= '0;
      res_stat_q <= stat_q;
      if (stat_q == ST_OK) begin
        if (op_q == OP_MAP) res_data_q <= DataW'(id_q);
        if (op_q == OP_LOAD) res_data_q <= word_rd_q;
        if (op_q == OP_LOAD_PRG) res_ctr_q <= off_q[CounterW-1:0];
      end
    end
  end

  assign data_o        = res_data_q;
  assign new_counter_o = res_ctr_q;
  assign status_code_o = res_stat_q;

`ifndef SYNTHESIS
  a_id_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fresh_q != '0) && (free_cnt_q < fresh_q))
    else $error("free id count exceeds allocated ids");
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_FILL || cmd_i == CMD_COPY_RD) |-> cnt_q < walk_len_q)
    else $error("walk counter beyond segment length");
  a_map_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_EVAL && op_q == OP_MAP && stat_d == ST_OK) |=> id_q != '0)
    else $error("map handed out segment zero");
`endif

endmodule

/* design/smu_controller.sv */
// ----------------------------------------------------------------------------
// smu_controller
// Sequencer: accepts an item, runs lookup, check, walk and result phases.
// ----------------------------------------------------------------------------
module smu_controller
  import smu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ctl_status_t dp_status_i,
  output cmd_e        cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and command
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LATCH;
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd_o   = CMD_LOOKUP;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o   = CMD_EVAL;
        state_d = S_FINISH;
        if (dp_status_i.status == ST_OK) begin
          case (dp_status_i.op)
            OP_MAP:      state_d = S_FILL;
            OP_LOAD_PRG: state_d = S_COPY_RD;
            OP_LOAD:     state_d = S_WORD_WAIT;
            default:     state_d = S_FINISH;
          endcase
        end
      end
      S_FILL: begin
        if (dp_status_i.walk_done) begin
          cmd_o   = CMD_FILL_END;
          state_d = S_FINISH;
        end else begin
          cmd_o = CMD_FILL;
        end
      end
      S_COPY_RD: begin
        if (dp_status_i.walk_done) begin
          cmd_o   = CMD_COPY_END;
          state_d = S_FINISH;
        end else begin
          cmd_o   = CMD_COPY_RD;
          state_d = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        cmd_o   = CMD_COPY_WR;
        state_d = S_COPY_RD;
      end
      S_WORD_WAIT: state_d = S_FINISH;
      S_FINISH: begin
        // Hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_finish_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && out_valid_q && !out_ready_i) |=> state_q == S_FINISH)
    else $error("result overwritten before transfer");
  a_copy_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY_WR) |-> $past(cmd_o) == CMD_COPY_RD)
    else $error("copy write without preceding read");
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_LATCH) |=> state_q == S_LOOKUP)
    else $error("accepted item did not start lookup");
`endif

endmodule

/* design/segmented_memory_unit_core.sv */
// An item passes lookup and check, then a segment fill (map), a wait for the
// word read (load) or a copy into segment zero (load program), then the result
// register. Throughput: one item in flight; the next item is taken once the
// current result is registered. A filled word is one access on the single
// word port, a copied word a read and a write. Reset clears control state and
// the free id count, sets the fresh id count to one; no memory needs clearing.
// ----------------------------------------------------------------------------
// segmented_memory_unit_core
// Segmented word memory with map, unmap, load, store and load program.
// ----------------------------------------------------------------------------
module segmented_memory_unit_core
  import smu_pkg::*;
#(
  parameter int NUM_SEGMENTS  = NumSegmentsDef,
  parameter int SEGMENT_WORDS = SegmentWordsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  smu_in_if.sink    in_i,
  smu_out_if.source out_o
);

  cmd_e        cmd;
  ctl_status_t dp_status;

  smu_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  smu_datapath #(
    .NUM_SEGMENTS  (NUM_SEGMENTS),
    .SEGMENT_WORDS (SEGMENT_WORDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (in_i.op),
    .segment_i     (in_i.segment),
    .offset_i      (in_i.offset),
    .value_i       (in_i.value),
    .status_o      (dp_status),
    .data_o        (out_o.data),
    .new_counter_o (out_o.new_counter),
    .status_code_o (out_o.status)
  );

endmodule
